>>> design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ALIGNED = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam int unsigned HDR_OVERHEAD = 2;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    CMD_IDLE   = 5'd0,
    CMD_LOAD   = 5'd1,   // latch request, set walker to zero
    CMD_RDWALK = 5'd2,   // issue read at walker
    CMD_STEP   = 5'd3,   // evaluate read data, advance walker
    CMD_SPLIT  = 5'd4,   // write remainder header
    CMD_TAKE   = 5'd5,   // write allocated header
    CMD_ALIGN  = 5'd6,   // write aligned header, shrink leading block
    CMD_RDH    = 5'd7,   // read header at h
    CMD_LOOKUP = 5'd8,   // check looked-up header
    CMD_RELH   = 5'd9,   // mark h free
    CMD_RDN    = 5'd10,  // read next of h
    CMD_MRGN   = 5'd11,  // merge next into h
    CMD_PWALK  = 5'd12,  // set walker to zero for previous search
    CMD_PSTEP  = 5'd13,  // previous search step
    CMD_MRGP   = 5'd14,  // merge h into previous
    CMD_DONE   = 5'd15,  // latch result
    CMD_CLR    = 5'd16   // clearing pass write
  } ffha_cmd_t;

  typedef struct packed {
    logic found;      // walk hit a fitting free block
    logic walk_end;   // walker reached heap end
    logic bad_req;    // status not OK: zero size, bad alignment, no space or bad lookup
    logic need_align; // aligned split applies
    logic lookup_ok;
    logic next_free;  // next block exists and is free
    logic prev_hit;   // previous search reached h
    logic prev_end;   // previous search reached or passed h
    logic clr_done;
    logic is_query;
    logic is_free;
    logic split;      // fitted block larger than request
  } ffha_stat_t;
endpackage
`default_nettype wire

>>> design/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing.
// Latency: a walk of the block chain, plus the header updates; free adds a
// second walk for the previous block.
// Throughput: one item at a time, set by the single port of the header memory.
// Reset: a clearing pass over every header address initializes the header memory.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int HEAP_UNITS = 65536,
  parameter int UNIT_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation[1:0], request_bytes[21:2], alignment_bytes[38:22],
  // payload_offset[58:39], kernel_context[59], owner_id[75:60]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], result_offset[21:2], block_bytes[41:22]
  output logic [47:0]      m_tdata
);
  import ffha_pkg::*;
  ffha_cmd_t  cmd;
  ffha_stat_t stat;
  logic busy, done, in_fire;
  logic [1:0] st;
  logic [19:0] roff, bb;
  logic [15:0] own;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  // Owner only recorded in kernel context.
  assign own = s_tdata[59] ? s_tdata[75:60] : 16'd0;

  ffha_ctrl u_ctrl (.clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_tdata[1:0]),
    .out_free(!m_tvalid || m_tready), .stat(stat), .cmd(cmd), .busy(busy), .done(done));

  ffha_datapath #(.HEAP_UNITS(HEAP_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(s_tdata[1:0]), .in_req(s_tdata[21:2]),
    .in_align(s_tdata[38:22]), .in_off(s_tdata[58:39]), .in_owner(own),
    .stat(stat), .status(st), .result_offset(roff), .block_bytes(bb));

  // Output register: hold the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (done) m_tvalid <= 1'b1;
    end
    if (done) m_tdata <= {6'd0, bb, roff, st};
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !s_tready || m_tvalid) else $error("accept during result");
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !done) else $error("result too early");
  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> m_tdata[41:2] == '0)
    else $error("payload on error");
`endif
endmodule
`default_nettype wire

>>> design/ffha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> design/ffha_datapath.sv
// Datapath: header memory, walker, request registers and result.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_datapath #(
  parameter int HEAP_UNITS = 65536,
  parameter int UNIT_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ffha_pkg::ffha_cmd_t cmd,
  input  wire logic [1:0]          in_op,
  input  wire logic [19:0]         in_req,
  input  wire logic [16:0]         in_align,
  input  wire logic [19:0]         in_off,
  input  wire logic [15:0]         in_owner,
  output ffha_pkg::ffha_stat_t     stat,
  output logic [1:0]               status,
  output logic [19:0]              result_offset,
  output logic [19:0]              block_bytes
);
  import ffha_pkg::*;
  localparam int AW = $clog2(HEAP_UNITS);
  localparam int UB = $clog2(UNIT_BYTES);
  localparam int WW = AW + 2;           // walker, holds past-end values
  localparam int EW = 34;               // header word: alloc, units(16), owner(16), valid

  logic [1:0]  op;
  logic [19:0] req;
  logic [16:0] align;
  logic [15:0] owner;
  logic [WW-1:0] w, h, h2, units, q2;
  logic [19:0] roff, bsz;
  logic [1:0]  st;
  logic [AW-1:0] clr;
  logic        clr_done;
  logic        off_ok_r;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic          r_valid, r_alloc;
  logic [15:0]   r_units, r_owner;
  logic [15:0]   h_units, h_owner;

  assign r_valid = rdata[0];
  assign r_owner = rdata[16:1];
  assign r_units = rdata[32:17];
  assign r_alloc = rdata[33];

  ffha_ram #(.WIDTH(EW), .DEPTH(HEAP_UNITS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  function automatic logic [EW-1:0] pack_hdr(logic a, logic [15:0] u, logic [15:0] o,
                                             logic v);
    return {a, u, o, v};
  endfunction

  function automatic logic [WW+UB:0] tot_in(logic [1:0] o, logic [19:0] r, logic [16:0] a);
    return (WW+UB+1)'(r) + ((o == OP_ALIGNED) ?
           (WW+UB+1)'(a) + (WW+UB+1)'(HDR_OVERHEAD * UNIT_BYTES) : '0);
  endfunction
  function automatic logic [WW+UB:0] pbytes_w(logic [WW-1:0] x);
    return (WW+UB+1)'(x + WW'(1)) << UB;
  endfunction
  function automatic logic [WW-1:0] q2c_w(logic [WW-1:0] x);
    logic [WW+UB:0] p, a;
    p = pbytes_w(x);
    a = (p + (WW+UB+1)'(HDR_OVERHEAD * UNIT_BYTES) + (WW+UB+1)'(align)
        - (WW+UB+1)'(1)) & ~((WW+UB+1)'(align) - (WW+UB+1)'(1));
    return WW'(a >> UB);
  endfunction

  logic [WW-1:0] nxt;
  logic [WW+UB:0] pbytes, abytes;
  assign nxt = w + WW'(r_units) + WW'(1);
  assign pbytes = (WW+UB+1)'(h + WW'(1)) << UB;
  assign abytes = (pbytes + (WW+UB+1)'(HDR_OVERHEAD * UNIT_BYTES) + (WW+UB+1)'(align)
                  - (WW+UB+1)'(1)) & ~((WW+UB+1)'(align) - (WW+UB+1)'(1));

  // Lookup of payload_offset.
  logic [WW-1:0] lh;
  logic          off_ok;
  assign lh = WW'(in_off >> UB) - WW'(1);
  assign off_ok = (in_off[UB-1:0] == '0) && (in_off >= 20'(UNIT_BYTES))
                  && (lh < WW'(HEAP_UNITS));

  always_comb begin
    we = 1'b0;
    addr = w[AW-1:0];
    wdata = '0;
    case (cmd)
      CMD_CLR: begin
        we = 1'b1; addr = clr;
        wdata = (clr == '0) ? pack_hdr(1'b0, 16'(HEAP_UNITS - 1), 16'd0, 1'b1) : '0;
      end
      CMD_SPLIT: begin
        we = 1'b1; addr = AW'(w + WW'(1) + units);
        wdata = pack_hdr(1'b0, r_units - 16'(units) - 16'd1, 16'd0, 1'b1);
      end
      CMD_TAKE: begin
        we = 1'b1; addr = w[AW-1:0];
        wdata = pack_hdr(1'b1, stat.split ? 16'(units) : r_units, owner, 1'b1);
      end
      CMD_ALIGN: begin
        we = 1'b1; addr = h2[AW-1:0];
        wdata = pack_hdr(1'b1, h_units - 16'(q2 - h - WW'(1)), h_owner, 1'b1);
      end
      CMD_RDH, CMD_LOOKUP: addr = h[AW-1:0];
      CMD_RELH: begin
        we = 1'b1; addr = h[AW-1:0];
        wdata = pack_hdr(1'b0, h_units, 16'd0, 1'b1);
      end
      CMD_RDN: addr = AW'(h + WW'(h_units) + WW'(1));
      CMD_MRGN: begin
        // Grow h over the free next block; the absorbed header stays free.
        we = 1'b1; addr = h[AW-1:0];
        wdata = pack_hdr(1'b0, h_units + r_units + 16'd1, 16'd0, 1'b1);
      end
      CMD_MRGP: begin
        we = !r_alloc; addr = w[AW-1:0];
        wdata = pack_hdr(r_alloc, r_units + h_units + 16'd1, r_owner, r_valid);
      end
      default: addr = w[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd == CMD_CLR) begin
      clr <= clr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op <= in_op; req <= in_req; align <= in_align; owner <= in_owner;
        w <= '0; roff <= '0; bsz <= '0;
        units <= WW'((tot_in(in_op, in_req, in_align)) >> UB) + WW'(1);
        h <= lh;
        if ((in_op == OP_ALLOC || in_op == OP_ALIGNED) && in_req == 20'd0) st <= ST_ZERO;
        else if (in_op == OP_ALIGNED && in_align != 17'd0 &&
                 (in_align & (in_align - 17'd1)) != 17'd0) st <= ST_INVALID;
        else st <= ST_OK;
      end
      CMD_STEP: begin
        if (stat.found) h <= w;
        else w <= nxt;
        if (stat.walk_end) st <= ST_NOSPACE;
      end
      CMD_TAKE: begin
        h <= w; roff <= 20'(pbytes_w(w));
        h_units <= stat.split ? 16'(units) : r_units;
        h_owner <= owner;
        q2 <= q2c_w(w);
        h2 <= q2c_w(w) - WW'(1);
      end
      CMD_ALIGN: begin
        roff <= 20'(abytes);
        h_units <= 16'(h2 - h - WW'(1));
      end
      CMD_LOOKUP: begin
        h_units <= r_units; h_owner <= r_owner;
        bsz <= 20'(r_units) << UB;
        if (!stat.lookup_ok) st <= ST_INVALID;
      end
      CMD_MRGN: h_units <= h_units + r_units + 16'd1;
      CMD_PWALK: w <= '0;
      CMD_PSTEP: if (!stat.prev_hit) w <= nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) if (cmd == CMD_LOAD) off_ok_r <= off_ok;

  logic [WW-1:0] hn;
  assign hn = h + WW'(h_units) + WW'(1);
  assign stat.found      = (w < WW'(HEAP_UNITS)) && !r_alloc && (WW'(r_units) >= units);
  assign stat.walk_end   = (w >= WW'(HEAP_UNITS));
  assign stat.bad_req    = (st != ST_OK);
  assign stat.need_align = (op == OP_ALIGNED) && (align != 17'd0) &&
                           ((pbytes & (WW+UB+1)'(align - 17'd1)) != '0) &&
                           (h2 < WW'(HEAP_UNITS)) && (q2 - h - WW'(1) <= WW'(h_units));
  assign stat.lookup_ok  = off_ok_r && r_valid && r_alloc;
  assign stat.next_free  = (hn < WW'(HEAP_UNITS)) && !r_alloc;
  assign stat.prev_hit   = (nxt == h);
  assign stat.prev_end   = (w >= h);
  assign stat.clr_done   = clr_done;
  assign stat.is_query   = (op == OP_QUERY);
  assign stat.is_free    = (op == OP_FREE);
  assign stat.split      = (WW'(r_units) != units);
  assign clr_done = (clr == AW'(HEAP_UNITS - 1));

  assign status        = st;
  assign result_offset = (st == ST_OK && !stat.is_free && !stat.is_query) ? roff : '0;
  assign block_bytes   = (st == ST_OK && stat.is_query) ? bsz : '0;
endmodule
`default_nettype wire

>>> design/ffha_ctrl.sv
// Controller state machine for the heap allocator.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire logic [1:0]           in_op,
  input  wire logic                 out_free,
  input  wire ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_cmd_t       cmd,
  output logic                      busy,
  output logic                      done
);
  import ffha_pkg::*;
  typedef enum logic [13:0] {
    S_CLR = 14'd1, S_IDLE = 14'd2, S_RD = 14'd4, S_STEP = 14'd8, S_SPLIT = 14'd16,
    S_TAKE = 14'd32, S_ALIGN = 14'd64, S_RDH = 14'd128, S_LOOK = 14'd256,
    S_RELH = 14'd512, S_RDN = 14'd1024, S_MRGN = 14'd2048, S_PRD = 14'd4096,
    S_DONE = 14'd8192
  } st_t;
  st_t state, state_next;
  logic pwalk, pwalk_next, pmerge, pmerge_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; pwalk <= 1'b0; pmerge <= 1'b0;
    end else begin
      state <= state_next; pwalk <= pwalk_next; pmerge <= pmerge_next;
    end
  end

  always_comb begin
    state_next = state; cmd = CMD_IDLE; pwalk_next = pwalk; pmerge_next = 1'b0;
    done = 1'b0;
    case (state)
      S_CLR: begin cmd = CMD_CLR; if (stat.clr_done) state_next = S_IDLE; end
      S_IDLE: if (in_fire) begin
        cmd = CMD_LOAD; pwalk_next = 1'b0;
        state_next = (in_op == OP_FREE || in_op == OP_QUERY) ? S_RDH : S_RD;
      end
      S_RD: begin
        if (stat.bad_req) state_next = S_DONE;
        else begin cmd = pwalk ? CMD_PWALK : CMD_RDWALK; state_next = S_STEP; end
        if (pwalk) begin cmd = CMD_RDWALK; end
      end
      S_STEP: begin
        if (pwalk) begin
          cmd = CMD_PSTEP;
          if (stat.prev_end) state_next = S_DONE;
          else if (stat.prev_hit) state_next = S_PRD;
          else state_next = S_RD;
        end else begin
          cmd = CMD_STEP;
          if (stat.walk_end) state_next = S_DONE;
          else if (stat.found) state_next = stat.split ? S_SPLIT : S_TAKE;
          else state_next = S_RD;
        end
      end
      S_SPLIT: begin cmd = CMD_SPLIT; state_next = S_TAKE; end
      S_TAKE: begin cmd = CMD_TAKE; state_next = S_ALIGN; end
      S_ALIGN: if (stat.need_align) begin
        cmd = CMD_ALIGN; state_next = S_RELH;
      end else state_next = S_DONE;
      S_RDH: begin cmd = CMD_RDH; state_next = stat.bad_req ? S_DONE : S_LOOK; end
      S_LOOK: begin
        cmd = CMD_LOOKUP;
        if (!stat.lookup_ok || stat.is_query) state_next = S_DONE;
        else state_next = S_RELH;
      end
      S_RELH: begin cmd = CMD_RELH; state_next = S_RDN; end
      S_RDN: begin cmd = CMD_RDN; state_next = S_MRGN; end
      S_MRGN: begin
        if (stat.next_free) cmd = CMD_MRGN;
        pwalk_next = 1'b1;
        state_next = S_PRD;
        pmerge_next = 1'b1;
      end
      S_PRD: begin
        if (pmerge) begin cmd = CMD_PWALK; state_next = S_RD; end
        else begin cmd = CMD_MRGP; state_next = S_DONE; end
      end
      S_DONE: begin
        cmd = CMD_DONE;
        if (out_free) begin done = 1'b1; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire
